FILE: src/tcqs_pkg.sv
// Shared types, constants and codes for the three-class quantum scheduler.
package tcqs_pkg;

  // Queue geometry and field widths
  localparam int QUEUE_DEPTH = 32;
  localparam int TIME_BITS   = 16;
  localparam int PID_BITS    = 8;
  localparam int NUM_Q       = 3;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = 2 + PTR_W;
  localparam int MEM_DEPTH   = 3 * (1 << PTR_W);

  // Configuration register indexes
  localparam logic [1:0] REG_SILVER_QUANTUM = 2'd0;
  localparam logic [1:0] REG_BRONZE_QUANTUM = 2'd1;
  localparam logic [1:0] REG_DRAW_LIMIT     = 2'd2;

  // Configuration reset values
  localparam logic [TIME_BITS-1:0] SILVER_QUANTUM_RST = TIME_BITS'(300);
  localparam logic [TIME_BITS-1:0] BRONZE_QUANTUM_RST = TIME_BITS'(400);
  localparam logic [4:0]           DRAW_LIMIT_RST     = 5'd10;

  // Commands
  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  // Queue classes
  localparam logic [1:0] CLS_GOLD   = 2'd0;
  localparam logic [1:0] CLS_SILVER = 2'd1;
  localparam logic [1:0] CLS_BRONZE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_DISP  = 2'd1;
  localparam logic [1:0] ST_IDLE  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One queue entry as stored in memory
  typedef struct packed {
    logic [PID_BITS-1:0]  pid;
    logic [TIME_BITS-1:0] burst;
  } entry_t;

  // Pointer update request for one queue
  typedef struct packed {
    logic       en;
    logic [1:0] q;
    logic       pop;
    logic       push;
  } ptr_upd_t;

endpackage

FILE: src/three_class_quantum_scheduler.sv
// Top level of the three-class quantum scheduler: control, config and result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: an add puts a process
//   id and burst time on the gold, silver or bronze queue; a dispatch pops one
//   process, gold first, else silver or bronze as picked by in_random_draw.
//   Result channel (out_valid/out_ready) returns exactly one result per request.
//   Config channel (cfg_valid/cfg_ready) writes silver/bronze quantum and the
//   bronze draw limit; it is always ready and should be used while idle.
// Sequence:
//   The accept cycle issues the queue head read to the entry memory; the execute
//   state then uses the read data, writes back a re-queued entry and updates the
//   pointers. A new request is not accepted until the last one leaves execute.
//   The result is loaded into the output register when execute completes.
// Reset and stalls:
//   Synchronous reset empties all queues and loads quantum 300/400, limit 10.
//   A waiting result does not block the next accept; the second request holds
//   in its execute cycle until the output register is free.
module three_class_quantum_scheduler
  import tcqs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  input  logic [PID_BITS-1:0]  in_process_id,
  input  logic [1:0]           in_process_class,
  input  logic [TIME_BITS-1:0] in_burst_time,
  input  logic [4:0]           in_random_draw,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [PID_BITS-1:0]  out_run_process_id,
  output logic [1:0]           out_run_class,
  output logic [TIME_BITS-1:0] out_granted_time,
  output logic [TIME_BITS-1:0] out_remaining_time,
  output logic                 out_finished,
  output logic                 out_all_empty,
  // config channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [TIME_BITS-1:0] cfg_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;

  // Config registers
  logic [TIME_BITS-1:0] silver_q_r, bronze_q_r;
  logic [4:0]           limit_r;

  // Request registers
  logic                 req_cmd_r;
  logic [PID_BITS-1:0]  req_pid_r;
  logic [TIME_BITS-1:0] req_burst_r;
  logic [1:0]           req_q_r;
  logic                 req_blk_r;
  logic [TIME_BITS-1:0] req_quant_r;

  // Output registers
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [PID_BITS-1:0]  out_pid_r;
  logic [1:0]           out_class_r;
  logic [TIME_BITS-1:0] out_grant_r;
  logic [TIME_BITS-1:0] out_remain_r;
  logic                 out_fin_r;
  logic                 out_empty_r;

  ptr_t [NUM_Q-1:0] head, tail;
  cnt_t [NUM_Q-1:0] cnt;
  logic             all_empty_nxt;
  ptr_upd_t         upd;

  logic              accept, go;
  logic [1:0]        qsel;
  logic              blk;
  logic [TIME_BITS-1:0] quant_sel;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  entry_t            mem_wr_data;
  entry_t            mem_rd_data;

  logic [1:0]           res_status;
  logic [PID_BITS-1:0]  res_pid;
  logic [1:0]           res_class;
  logic [TIME_BITS-1:0] res_grant;
  logic [TIME_BITS-1:0] res_remain;
  logic                 res_fin;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign go        = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // Queue selection at accept time
  always_comb begin
    if (in_command == CMD_ADD) begin
      case (in_process_class)
        CLS_GOLD:   qsel = CLS_GOLD;
        CLS_SILVER: qsel = CLS_SILVER;
        default:    qsel = CLS_BRONZE;
      endcase
      blk = (cnt[qsel] == CNT_W'(QUEUE_DEPTH));
    end else begin
      if (cnt[CLS_GOLD] != '0) begin
        qsel = CLS_GOLD;
      end else if (in_random_draw <= limit_r) begin
        qsel = CLS_BRONZE;
      end else begin
        qsel = CLS_SILVER;
      end
      blk = (cnt[qsel] == '0);
    end
    quant_sel = (qsel == CLS_SILVER) ? silver_q_r : bronze_q_r;
  end

  // Execute: grant computation, write-back and pointer update
  always_comb begin
    res_status  = ST_ADDED;
    res_pid     = '0;
    res_class   = CLS_GOLD;
    res_grant   = '0;
    res_remain  = '0;
    res_fin     = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = {req_q_r, tail[req_q_r]};
    mem_wr_data = '{pid: req_pid_r, burst: req_burst_r};
    upd         = '{en: 1'b0, q: req_q_r, pop: 1'b0, push: 1'b0};
    case (req_cmd_r)
      CMD_ADD: begin
        if (req_blk_r) begin
          res_status = ST_FULL;
        end else begin
          mem_wr_en  = go;
          upd.en     = go;
          upd.push   = 1'b1;
        end
      end
      default: begin
        if (req_blk_r) begin
          res_status = ST_IDLE;
        end else begin
          res_status = ST_DISP;
          res_pid    = mem_rd_data.pid;
          res_class  = req_q_r;
          upd.en     = go;
          upd.pop    = 1'b1;
          if ((req_q_r == CLS_GOLD) || (mem_rd_data.burst <= req_quant_r)) begin
            res_grant = mem_rd_data.burst;
            res_fin   = 1'b1;
          end else begin
            res_grant   = req_quant_r;
            res_remain  = mem_rd_data.burst - req_quant_r;
            mem_wr_en   = go;
            mem_wr_data = '{pid: mem_rd_data.pid, burst: res_remain};
            upd.push    = 1'b1;
          end
        end
      end
    endcase
  end

  // Control FSM
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  if (go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      silver_q_r  <= SILVER_QUANTUM_RST;
      bronze_q_r  <= BRONZE_QUANTUM_RST;
      limit_r     <= DRAW_LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_SILVER_QUANTUM: silver_q_r <= cfg_data;
          REG_BRONZE_QUANTUM: bronze_q_r <= cfg_data;
          REG_DRAW_LIMIT:     limit_r    <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd_r   <= in_command;
      req_pid_r   <= in_process_id;
      req_burst_r <= in_burst_time;
      req_q_r     <= qsel;
      req_blk_r   <= blk;
      req_quant_r <= quant_sel;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (go) begin
      out_status_r <= res_status;
      out_pid_r    <= res_pid;
      out_class_r  <= res_class;
      out_grant_r  <= res_grant;
      out_remain_r <= res_remain;
      out_fin_r    <= res_fin;
      out_empty_r  <= all_empty_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_run_process_id = out_pid_r;
  assign out_run_class      = out_class_r;
  assign out_granted_time   = out_grant_r;
  assign out_remaining_time = out_remain_r;
  assign out_finished       = out_fin_r;
  assign out_all_empty      = out_empty_r;

  tcqs_qptr u_qptr (
    .clk           (clk),
    .rst_n         (rst_n),
    .upd           (upd),
    .head          (head),
    .cnt           (cnt),
    .tail          (tail),
    .all_empty_nxt (all_empty_nxt)
  );

  tcqs_qmem u_qmem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (accept && (in_command == CMD_DISPATCH)),
    .rd_addr ({qsel, head[qsel]}),
    .rd_data (mem_rd_data)
  );

endmodule

FILE: src/tcqs_qmem.sv
// Entry memory shared by the three queues, one write and one registered read port.
module tcqs_qmem
  import tcqs_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [MEM_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, data valid in the cycle after rd_en
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/tcqs_qptr.sv
// Head and count registers of the three queues, with tail slot and empty status.
module tcqs_qptr
  import tcqs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  ptr_upd_t               upd,
  output ptr_t [NUM_Q-1:0]       head,
  output cnt_t [NUM_Q-1:0]       cnt,
  output ptr_t [NUM_Q-1:0]       tail,
  output logic                   all_empty_nxt
);

  ptr_t            head_r   [NUM_Q];
  cnt_t            cnt_r    [NUM_Q];
  ptr_t            head_nxt [NUM_Q];
  cnt_t            cnt_nxt  [NUM_Q];
  logic [PTR_W:0]  head_inc [NUM_Q];
  logic [CNT_W:0]  tail_sum [NUM_Q];

  // Next pointers: pop advances head, count moves by push minus pop
  always_comb begin
    all_empty_nxt = 1'b1;
    for (int i = 0; i < NUM_Q; i++) begin
      head_inc[i] = {1'b0, head_r[i]} + (PTR_W+1)'(1);
      tail_sum[i] = (CNT_W+1)'(head_r[i]) + (CNT_W+1)'(cnt_r[i]);
      head[i]     = head_r[i];
      cnt[i]      = cnt_r[i];
      if (tail_sum[i] >= (CNT_W+1)'(QUEUE_DEPTH)) begin
        tail[i] = PTR_W'(tail_sum[i] - (CNT_W+1)'(QUEUE_DEPTH));
      end else begin
        tail[i] = PTR_W'(tail_sum[i]);
      end
      head_nxt[i] = head_r[i];
      cnt_nxt[i]  = cnt_r[i];
      if (upd.en && (upd.q == 2'(i))) begin
        if (upd.pop) begin
          if (head_inc[i] == (PTR_W+1)'(QUEUE_DEPTH)) begin
            head_nxt[i] = '0;
          end else begin
            head_nxt[i] = head_inc[i][PTR_W-1:0];
          end
        end
        cnt_nxt[i] = cnt_r[i] + CNT_W'(upd.push) - CNT_W'(upd.pop);
      end
      if (cnt_nxt[i] != '0) begin
        all_empty_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_Q; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_Q; i++) begin
        head_r[i] <= head_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
    end
  end

endmodule

FILE: src/tcqs_checker.sv
// Port-level checks for the scheduler, bound to the top level.
module tcqs_checker
  import tcqs_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           out_status,
  input logic [PID_BITS-1:0]  out_run_process_id,
  input logic [1:0]           out_run_class,
  input logic [TIME_BITS-1:0] out_granted_time,
  input logic [TIME_BITS-1:0] out_remaining_time,
  input logic                 out_finished
);

  // A result stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // One request in flight: ready drops after each accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is executing");

  // Idle dispatch reports nothing
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_IDLE) |->
      (out_run_process_id == '0) && (out_granted_time == '0) && !out_finished)
    else $error("idle result carries data");

  // Finished only on dispatch, with nothing owed
  a_fin_disp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> (out_status == ST_DISP) && (out_remaining_time == '0))
    else $error("finished flag on a wrong result");

  // A preempted process is never gold and still owes time
  a_preempt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DISP) && !out_finished |->
      (out_run_class != CLS_GOLD) && (out_remaining_time != '0))
    else $error("bad preempted dispatch");

endmodule

bind three_class_quantum_scheduler tcqs_checker u_tcqs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_run_process_id (out_run_process_id),
  .out_run_class      (out_run_class),
  .out_granted_time   (out_granted_time),
  .out_remaining_time (out_remaining_time),
  .out_finished       (out_finished)
);

FILE: test/sched_scoreboard.sv
// Scoreboard for the three-class quantum scheduler: predicts every result and checks it.
module sched_scoreboard
  import tcqs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_command,
  input  logic [PID_BITS-1:0]  in_process_id,
  input  logic [1:0]           in_process_class,
  input  logic [TIME_BITS-1:0] in_burst_time,
  input  logic [4:0]           in_random_draw,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [1:0]           out_status,
  input  logic [PID_BITS-1:0]  out_run_process_id,
  input  logic [1:0]           out_run_class,
  input  logic [TIME_BITS-1:0] out_granted_time,
  input  logic [TIME_BITS-1:0] out_remaining_time,
  input  logic                 out_finished,
  input  logic                 out_all_empty,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [TIME_BITS-1:0] cfg_data,
  output int                   mismatch_count,
  output int                   outstanding
);

  typedef struct packed {
    logic [1:0]           status;
    logic [PID_BITS-1:0]  run_pid;
    logic [1:0]           run_class;
    logic [TIME_BITS-1:0] granted;
    logic [TIME_BITS-1:0] remaining;
    logic                 finished;
    logic                 all_empty;
  } sched_result_t;

  // Shadow copy of the ready queues and the registers
  entry_t               gold_q[$];
  entry_t               silver_q[$];
  entry_t               bronze_q[$];
  logic [TIME_BITS-1:0] silver_quantum;
  logic [TIME_BITS-1:0] bronze_quantum;
  logic [4:0]           draw_limit;

  // Results owed by the block, oldest first
  sched_result_t expected_results[$];
  sched_result_t oldest;

  function automatic int queue_len(logic [1:0] q);
    case (q)
      CLS_GOLD:   return gold_q.size();
      CLS_SILVER: return silver_q.size();
      default:    return bronze_q.size();
    endcase
  endfunction

  function automatic void push_entry(logic [1:0] q, entry_t e);
    case (q)
      CLS_GOLD:   gold_q.push_back(e);
      CLS_SILVER: silver_q.push_back(e);
      default:    bronze_q.push_back(e);
    endcase
  endfunction

  function automatic entry_t pop_entry(logic [1:0] q);
    case (q)
      CLS_GOLD:   return gold_q.pop_front();
      CLS_SILVER: return silver_q.pop_front();
      default:    return bronze_q.pop_front();
    endcase
  endfunction

  // Apply one request to the shadow queues and return the result it produces
  function automatic sched_result_t schedule_step(logic cmd, logic [PID_BITS-1:0] pid,
                                                  logic [1:0] cls,
                                                  logic [TIME_BITS-1:0] burst,
                                                  logic [4:0] draw);
    sched_result_t        r;
    entry_t               e;
    logic [1:0]           pick;
    logic [TIME_BITS-1:0] quantum;
    r       = '0;
    quantum = '0;
    if (cmd == CMD_ADD) begin
      // classes above silver all land in bronze
      pick = (cls == CLS_GOLD) ? CLS_GOLD : (cls == CLS_SILVER) ? CLS_SILVER : CLS_BRONZE;
      if (queue_len(pick) >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        e.pid   = pid;
        e.burst = burst;
        push_entry(pick, e);
        r.status = ST_ADDED;
      end
    end else begin
      if (gold_q.size() != 0) begin
        pick = CLS_GOLD;
      end else if (draw <= draw_limit) begin
        pick    = CLS_BRONZE;
        quantum = bronze_quantum;
      end else begin
        pick    = CLS_SILVER;
        quantum = silver_quantum;
      end
      // an empty picked queue gives idle, the other queue is not tried
      if (queue_len(pick) == 0) begin
        r.status = ST_IDLE;
      end else begin
        e           = pop_entry(pick);
        r.status    = ST_DISP;
        r.run_pid   = e.pid;
        r.run_class = pick;
        if (pick == CLS_GOLD || e.burst <= quantum) begin
          r.granted  = e.burst;
          r.finished = 1'b1;
        end else begin
          // time left: grant one slice and requeue at the tail
          r.granted   = quantum;
          r.remaining = e.burst - quantum;
          e.burst     = r.remaining;
          push_entry(pick, e);
        end
      end
    end
    r.all_empty = (gold_q.size() == 0) && (silver_q.size() == 0) && (bronze_q.size() == 0);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Watch all three channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      gold_q.delete();
      silver_q.delete();
      bronze_q.delete();
      expected_results.delete();
      silver_quantum = SILVER_QUANTUM_RST;
      bronze_quantum = BRONZE_QUANTUM_RST;
      draw_limit     = DRAW_LIMIT_RST;
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SILVER_QUANTUM: silver_quantum = cfg_data;
          REG_BRONZE_QUANTUM: bronze_quantum = cfg_data;
          REG_DRAW_LIMIT:     draw_limit     = cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result accepted with no request outstanding");
          mismatch_count++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("status", oldest.status, out_status);
          check_field("run_process_id", oldest.run_pid, out_run_process_id);
          check_field("run_class", oldest.run_class, out_run_class);
          check_field("granted_time", oldest.granted, out_granted_time);
          check_field("remaining_time", oldest.remaining, out_remaining_time);
          check_field("finished", oldest.finished, out_finished);
          check_field("all_empty", oldest.all_empty, out_all_empty);
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(schedule_step(in_command, in_process_id,
                                                 in_process_class, in_burst_time,
                                                 in_random_draw));
      end
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: test/tb_top.sv
// Testbench top for the three-class quantum scheduler: clock, reset, stimulus and verdict.
module tb_top;
  import tcqs_pkg::*;

  localparam logic [1:0] REG_UNUSED     = 2'd3;
  localparam logic [1:0] CLS_BRONZE_ALT = 2'd3;
  localparam int SEGMENTS     = 4;
  localparam int SEG_ITEMS    = 40;
  localparam int DRAIN_CYCLES = 4;
  localparam int END_CYCLES   = 10;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_command;
  logic [PID_BITS-1:0]  in_process_id;
  logic [1:0]           in_process_class;
  logic [TIME_BITS-1:0] in_burst_time;
  logic [4:0]           in_random_draw;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_status;
  logic [PID_BITS-1:0]  out_run_process_id;
  logic [1:0]           out_run_class;
  logic [TIME_BITS-1:0] out_granted_time;
  logic [TIME_BITS-1:0] out_remaining_time;
  logic                 out_finished;
  logic                 out_all_empty;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [TIME_BITS-1:0] cfg_data;
  int                   mismatch_count;
  int                   outstanding;
  bit                   quiet = 1'b0;

  three_class_quantum_scheduler dut (.*);

  sched_scoreboard sb (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side backpressure: random stall bursts, none in the quiet part
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) repeat (60) @(posedge clk);
      else repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Present one request, with an optional idle burst first; valid stays high on return
  task automatic send_request(input logic cmd, input logic [PID_BITS-1:0] pid,
                              input logic [1:0] cls, input logic [TIME_BITS-1:0] burst,
                              input logic [4:0] draw);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_process_id    <= pid;
    in_process_class <= cls;
    in_burst_time    <= burst;
    in_random_draw   <= draw;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random request; fill traffic mostly adds to one focus class
  task automatic send_random(input traffic_mix_t mix, input logic [1:0] focus);
    int                   add_pct;
    int                   pick;
    logic                 cmd;
    logic [1:0]           cls;
    logic [TIME_BITS-1:0] burst;
    logic [4:0]           draw;
    case (mix)
      MIX_FILL:  add_pct = 85;
      MIX_DRAIN: add_pct = 20;
      default:   add_pct = 50;
    endcase
    cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_DISPATCH;
    if (mix == MIX_FILL && $urandom_range(0, 9) != 0) begin
      cls = focus;
    end else begin
      pick = $urandom_range(0, 9);
      cls  = (pick < 2) ? CLS_GOLD : (pick < 6) ? CLS_SILVER :
             (pick < 8) ? CLS_BRONZE : CLS_BRONZE_ALT;
    end
    case ($urandom_range(0, 9))
      0:       burst = '0;
      1:       burst = '1;
      2, 3:    burst = TIME_BITS'($urandom);
      default: burst = TIME_BITS'($urandom_range(0, 1500));
    endcase
    draw = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(30, 31)) : 5'($urandom_range(0, 29));
    send_request(cmd, PID_BITS'($urandom), cls, burst, draw);
  endtask

  // Register write; valid stays high on return
  task automatic write_reg(input logic [1:0] idx, input logic [TIME_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Wait until every result is back, sampled away from the active edge
  task automatic wait_drained();
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One configuration setting followed by segments of random traffic
  task automatic run_phase(input logic [TIME_BITS-1:0] sq, input logic [TIME_BITS-1:0] bq,
                           input logic [TIME_BITS-1:0] lim, input bit touch_unused);
    int           seg;
    int           i;
    traffic_mix_t mix;
    logic [1:0]   focus;
    wait_drained();
    write_reg(REG_SILVER_QUANTUM, sq);
    write_reg(REG_BRONZE_QUANTUM, bq);
    write_reg(REG_DRAW_LIMIT, lim);
    if (touch_unused) write_reg(REG_UNUSED, TIME_BITS'($urandom));
    cfg_valid <= 1'b0;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      mix   = traffic_mix_t'($urandom_range(0, 2));
      focus = 2'($urandom_range(0, 3));
      for (i = 0; i < SEG_ITEMS; i++) send_random(mix, focus);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command       = CMD_ADD;
    in_process_id    = '0;
    in_process_class = CLS_GOLD;
    in_burst_time    = '0;
    in_random_draw   = '0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_SILVER_QUANTUM;
    cfg_data         = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle on empty queues, extremes, class aliases, slicing, no fallback
    send_request(CMD_DISPATCH, 8'h00, CLS_GOLD, 16'h0000, 5'd0);
    send_request(CMD_DISPATCH, 8'hFF, CLS_BRONZE_ALT, 16'hFFFF, 5'd31);
    send_request(CMD_ADD, 8'hFF, CLS_GOLD, 16'hFFFF, 5'd31);
    send_request(CMD_ADD, 8'h00, CLS_GOLD, 16'h0000, 5'd0);
    send_request(CMD_ADD, 8'h5A, CLS_SILVER, 16'd700, 5'd0);
    send_request(CMD_ADD, 8'h11, CLS_BRONZE, 16'd1000, 5'd0);
    send_request(CMD_ADD, 8'h22, CLS_BRONZE_ALT, 16'd400, 5'd0);
    send_request(CMD_ADD, 8'h33, CLS_BRONZE, 16'd0, 5'd0);
    send_request(CMD_DISPATCH, 8'h00, CLS_GOLD, 16'h0000, 5'd31);
    send_request(CMD_DISPATCH, 8'h00, CLS_GOLD, 16'h0000, 5'd0);
    send_request(CMD_DISPATCH, 8'h00, CLS_GOLD, 16'h0000, 5'd31);
    send_request(CMD_DISPATCH, 8'h00, CLS_GOLD, 16'h0000, 5'd30);
    send_request(CMD_DISPATCH, 8'h00, CLS_GOLD, 16'h0000, 5'd11);
    // silver now empty while bronze holds entries
    send_request(CMD_DISPATCH, 8'h00, CLS_GOLD, 16'h0000, 5'd11);
    send_request(CMD_DISPATCH, 8'h00, CLS_GOLD, 16'h0000, 5'd10);
    send_request(CMD_DISPATCH, 8'h00, CLS_GOLD, 16'h0000, 5'd0);
    send_request(CMD_DISPATCH, 8'h00, CLS_GOLD, 16'h0000, 5'd5);
    send_request(CMD_DISPATCH, 8'h00, CLS_GOLD, 16'h0000, 5'd5);
    send_request(CMD_DISPATCH, 8'h00, CLS_GOLD, 16'h0000, 5'd5);
    send_request(CMD_ADD, 8'hA5, CLS_SILVER, 16'h8000, 5'd29);
    send_request(CMD_DISPATCH, 8'h00, CLS_GOLD, 16'h0000, 5'd29);
    in_valid <= 1'b0;

    // Random traffic over several register settings
    run_phase(SILVER_QUANTUM_RST, BRONZE_QUANTUM_RST, 16'(DRAW_LIMIT_RST), 1'b0);
    run_phase(16'd1, 16'd1, 16'd0, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 16'd29, 1'b0);
    // zero slices: leftover time is requeued unchanged; limit 31 always picks bronze over silver
    run_phase(16'd0, 16'd0, 16'd31, 1'b0);
    run_phase(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)), 16'd30, 1'b1);
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 31)), 1'b0);
    run_phase(16'd50, 16'd700, 16'd15, 1'b0);
    quiet = 1'b1;
    // upper data bits are dropped by the limit register
    run_phase(SILVER_QUANTUM_RST, BRONZE_QUANTUM_RST, 16'hFFE5, 1'b0);

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
